// File: design/pffl_pkg.sv
package pffl_pkg;

   localparam int unsigned FRAME_W         = 10;
   localparam int unsigned LINK_W          = 11;
   localparam int unsigned TOTAL_W         = 11;
   localparam int unsigned REF_W           = 16;
   localparam int unsigned FRAME_LIMIT     = 2 ** FRAME_W;
   localparam int unsigned FRAME_COUNT_DEF = 1024;

   localparam logic [LINK_W-1:0] NULL_LINK = {LINK_W{1'b1}};

   typedef enum logic [1:0] {
      CMD_ADD     = 2'd0,
      CMD_ALLOC   = 2'd1,
      CMD_RELEASE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_KIND  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_RESERVED  = 2'd0,
      KIND_AVAILABLE = 2'd1,
      KIND_ALLOCATED = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_EXEC
   } fsm_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [FRAME_W-1:0] frame_number;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [FRAME_W-1:0] frame_out;
      logic [TOTAL_W-1:0] free_count;
      logic               frame_freed;
   } rsp_type;

   // one word of the kind/refcount table
   typedef struct packed {
      kind_type         kind;
      logic [REF_W-1:0] count;
   } kc_entry_type;

   typedef struct packed {
      logic accept;
      logic fire;
   } upd_ctrl_type;

endpackage

// File: design/pffl_ram.sv
module pffl_ram
   #(parameter int unsigned WIDTH = 8,
     parameter int unsigned DEPTH = 16,
     localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1)
   (input  logic             clock,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/pffl_update.sv
module pffl_update
   import pffl_pkg::*;
   #(parameter int unsigned FRAME_COUNT = FRAME_COUNT_DEF,
     localparam int unsigned TABLE_DEPTH =
        (FRAME_COUNT < FRAME_LIMIT) ? FRAME_COUNT : FRAME_LIMIT,
     localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH))
   (input  logic                          clock,
    input  logic                          reset,
    input  upd_ctrl_type                  ctrl,
    input  req_type                       req_data,
    input  logic [$bits(kc_entry_type)-1:0] kc_rdata,
    input  logic [LINK_W-1:0]             link_rdata,
    output logic [LINK_W-1:0]             head,
    output logic                          kc_we,
    output logic [ADDR_W-1:0]             kc_waddr,
    output kc_entry_type                  kc_wdata,
    output logic                          link_we,
    output logic [ADDR_W-1:0]             link_waddr,
    output logic [LINK_W-1:0]             link_wdata,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output rsp_type                       rsp_data);

   req_type            req_ff;
   logic [LINK_W-1:0]  head_ff, head_in;
   logic [LINK_W-1:0]  tail_ff, tail_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;
   kc_entry_type       kc_rd;
   logic               frame_ok;
   logic [REF_W-1:0]   count_dec;
   logic               wr_kc, wr_link;

   assign kc_rd     = kc_entry_type'(kc_rdata);
   assign frame_ok  = (32'(req_ff.frame_number) < TABLE_DEPTH);
   assign count_dec = kc_rd.count - REF_W'(1);

   always_comb begin
      head_in            = head_ff;
      tail_in            = tail_ff;
      total_in           = total_ff;
      wr_kc              = 1'b0;
      kc_waddr           = ADDR_W'(req_ff.frame_number);
      kc_wdata.kind      = KIND_AVAILABLE;
      kc_wdata.count     = '0;
      wr_link            = 1'b0;
      link_waddr         = ADDR_W'(req_ff.frame_number);
      link_wdata         = head_ff;
      rsp_in.status      = ST_KIND;
      rsp_in.frame_out   = req_ff.frame_number;
      rsp_in.frame_freed = 1'b0;
      case (cmd_type'(req_ff.command))
         CMD_ADD: begin
            if (frame_ok && kc_rd.kind == KIND_RESERVED) begin
               wr_kc = 1'b1;
               if (tail_ff == NULL_LINK) begin
                  head_in = LINK_W'(req_ff.frame_number);
               end else begin
                  // chain behind the current tail
                  wr_link    = 1'b1;
                  link_waddr = ADDR_W'(tail_ff);
                  link_wdata = LINK_W'(req_ff.frame_number);
               end
               tail_in       = LINK_W'(req_ff.frame_number);
               total_in      = total_ff + TOTAL_W'(1);
               rsp_in.status = ST_OK;
            end
         end
         CMD_ALLOC: begin
            if (head_ff == NULL_LINK) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               wr_kc          = 1'b1;
               kc_waddr       = ADDR_W'(head_ff);
               kc_wdata.kind  = KIND_ALLOCATED;
               kc_wdata.count = REF_W'(1);
               // an added tail's link is not written null, so spot the last listed frame by head == tail
               if (head_ff == tail_ff) begin
                  head_in = NULL_LINK;
                  tail_in = NULL_LINK;
               end else begin
                  head_in = link_rdata;
               end
               total_in         = total_ff - TOTAL_W'(1);
               rsp_in.frame_out = FRAME_W'(head_ff);
               rsp_in.status    = ST_OK;
            end
         end
         CMD_RELEASE: begin
            if (frame_ok && kc_rd.kind == KIND_ALLOCATED) begin
               wr_kc = 1'b1;
               if (count_dec == '0) begin
                  wr_link            = 1'b1;
                  head_in            = LINK_W'(req_ff.frame_number);
                  if (tail_ff == NULL_LINK) begin
                     tail_in = LINK_W'(req_ff.frame_number);
                  end
                  total_in           = total_ff + TOTAL_W'(1);
                  rsp_in.frame_freed = 1'b1;
               end else begin
                  kc_wdata.kind  = KIND_ALLOCATED;
                  kc_wdata.count = count_dec;
               end
               rsp_in.status = ST_OK;
            end
         end
         default: begin
            rsp_in.status = ST_KIND;
         end
      endcase
      rsp_in.free_count = total_in;
   end

   assign kc_we   = ctrl.fire && wr_kc;
   assign link_we = ctrl.fire && wr_link;

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         req_ff <= req_data;
      end
      if (ctrl.fire) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= NULL_LINK;
         tail_ff      <= NULL_LINK;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctrl.fire) begin
            head_ff      <= head_in;
            tail_ff      <= tail_in;
            total_ff     <= total_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign head      = head_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: design/page_frame_free_list.sv
// The tables are read at request accept; the update and the response are registered when
// the command fires, which waits while the previous response is still not taken. One word
// is in flight at a time, as each command reads its table entries and writes them back.
// Reset: head and tail go null, free count to zero, then a clearing pass over all
// min(FRAME_COUNT, 1024) entries marks each frame reserved; req_ready stays low meanwhile.
module page_frame_free_list
   import pffl_pkg::*;
   #(parameter int unsigned FRAME_COUNT = FRAME_COUNT_DEF)
   (input  logic    clock,
    input  logic    reset,
    input  logic    req_valid,
    output logic    req_ready,
    input  req_type req_data,
    output logic    rsp_valid,
    input  logic    rsp_ready,
    output rsp_type rsp_data);

   localparam int unsigned TABLE_DEPTH =
      (FRAME_COUNT < FRAME_LIMIT) ? FRAME_COUNT : FRAME_LIMIT;
   localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
   localparam int unsigned KC_W   = $bits(kc_entry_type);

   fsm_type            state_ff, state_in;
   logic [ADDR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic               clr_last, clearing, accept;
   upd_ctrl_type       ctrl;

   logic [LINK_W-1:0]  head;
   logic               upd_kc_we;
   logic [ADDR_W-1:0]  upd_kc_waddr;
   kc_entry_type       upd_kc_wdata;
   logic               kc_we;
   logic [ADDR_W-1:0]  kc_waddr;
   logic [KC_W-1:0]    kc_wdata;
   logic [KC_W-1:0]    kc_rdata;
   logic               link_we;
   logic [ADDR_W-1:0]  link_waddr;
   logic [LINK_W-1:0]  link_wdata;
   logic [LINK_W-1:0]  link_rdata;

   assign clr_last = (clr_cnt_ff == ADDR_W'(TABLE_DEPTH - 1));
   assign accept   = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_CLEAR: begin
            if (clr_last) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            if (accept) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (ctrl.fire) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      clearing    = 1'b0;
      ctrl.accept = accept;
      ctrl.fire   = 1'b0;
      case (state_ff)
         FSM_CLEAR: begin
            clearing = 1'b1;
         end
         FSM_IDLE: begin
            req_ready = 1'b1;
         end
         FSM_EXEC: begin
            // hold while the previous response is still waiting
            ctrl.fire = !rsp_valid || rsp_ready;
         end
         default: begin
            clearing = 1'b0;
         end
      endcase
   end

   assign clr_cnt_in = clearing ? clr_cnt_ff + ADDR_W'(1) : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FSM_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   assign kc_we    = clearing || upd_kc_we;
   assign kc_waddr = clearing ? clr_cnt_ff : upd_kc_waddr;
   assign kc_wdata = clearing ? KC_W'(0) : KC_W'(upd_kc_wdata);

   pffl_ram #(.WIDTH(KC_W), .DEPTH(TABLE_DEPTH)) u_kc_ram (
      .clock   (clock),
      .wr_en   (kc_we),
      .wr_addr (kc_waddr),
      .wr_data (kc_wdata),
      .rd_en   (accept),
      .rd_addr (ADDR_W'(req_data.frame_number)),
      .rd_data (kc_rdata));

   pffl_ram #(.WIDTH(LINK_W), .DEPTH(TABLE_DEPTH)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_en   (accept),
      .rd_addr (ADDR_W'(head)),
      .rd_data (link_rdata));

   pffl_update #(.FRAME_COUNT(FRAME_COUNT)) u_update (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .req_data   (req_data),
      .kc_rdata   (kc_rdata),
      .link_rdata (link_rdata),
      .head       (head),
      .kc_we      (upd_kc_we),
      .kc_waddr   (upd_kc_waddr),
      .kc_wdata   (upd_kc_wdata),
      .link_we    (link_we),
      .link_waddr (link_waddr),
      .link_wdata (link_wdata),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data));

endmodule

// File: design/pffl_checker.sv
module pffl_checker
   import pffl_pkg::*;
   #(parameter int unsigned FRAME_COUNT = FRAME_COUNT_DEF)
   (input logic    clock,
    input logic    reset,
    input logic    req_valid,
    input logic    req_ready,
    input req_type req_data,
    input logic    rsp_valid,
    input logic    rsp_ready,
    input rsp_type rsp_data);

   localparam int unsigned TABLE_DEPTH =
      (FRAME_COUNT < FRAME_LIMIT) ? FRAME_COUNT : FRAME_LIMIT;

   // one command in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted back to back");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.free_count) <= TABLE_DEPTH))
      else $error("free count above table size");

   a_empty_means_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_EMPTY) |->
         (rsp_data.free_count == '0 && !rsp_data.frame_freed))
      else $error("empty status with free frames");

   a_freed_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frame_freed) |->
         (rsp_data.status == ST_OK && rsp_data.free_count != '0))
      else $error("freed flag on failed release");

endmodule

bind page_frame_free_list pffl_checker #(.FRAME_COUNT(FRAME_COUNT)) u_pffl_checker (.*);

// File: tb/page_frame_free_list_tb.sv
`timescale 1ns / 1ps

module page_frame_free_list_tb;
   import pffl_pkg::*;

   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam int         HOLD_AT     = 150;
   localparam int         HOLD_CYCLES = 400;
   localparam int         QUIET_LO    = 700;
   localparam int         QUIET_HI    = 1000;
   localparam int         STALL_LIMIT = 6000;
   localparam int         TAIL_CYCLES = 8;

   typedef struct {
      req_type word;
      bit      drain_first;
   } pending_word_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   page_frame_free_list dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data));

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // frame table as the block should hold it
   kind_type           pf_kind  [FRAME_LIMIT];
   logic [LINK_W-1:0]  pf_next  [FRAME_LIMIT];
   logic [REF_W-1:0]   pf_count [FRAME_LIMIT];
   logic [LINK_W-1:0]  pf_head;
   logic [LINK_W-1:0]  pf_tail;
   logic [TOTAL_W-1:0] pf_total;

   pending_word_type frame_cmds_pending[$];
   rsp_type          frame_results_due[$];

   // list mirror used only to pick meaningful frames while building stimulus
   kind_type g_kind [FRAME_LIMIT];
   int       g_list[$];
   int       g_alloc[$];

   int total_words   = 0;
   int words_sent    = 0;
   int words_checked = 0;
   int errors        = 0;
   int n_add = 0, n_alloc = 0, n_release = 0, n_other = 0;
   int n_freed = 0, n_empty = 0, n_kind = 0, peak_free = 0;
   int hold_left     = 0;
   bit hold_done     = 1'b0;
   int stalled_cycles = 0;

   function automatic bit frame_in_range(logic [LINK_W-1:0] f);
      return int'(f) < FRAME_COUNT_DEF;
   endfunction

   function automatic rsp_type predict_frame_op(req_type w);
      rsp_type            r;
      logic [FRAME_W-1:0] f;
      logic [LINK_W-1:0]  h;
      f = w.frame_number;
      r.status      = ST_KIND;
      r.frame_out   = f;
      r.frame_freed = 1'b0;
      case (w.command)
         CMD_ADD: begin
            if (frame_in_range({1'b0, f}) && pf_kind[f] == KIND_RESERVED) begin
               pf_kind[f]  = KIND_AVAILABLE;
               pf_next[f]  = NULL_LINK;
               pf_count[f] = '0;
               if (pf_tail == NULL_LINK || !frame_in_range(pf_tail))
                  pf_head = {1'b0, f};
               else
                  pf_next[pf_tail[FRAME_W-1:0]] = {1'b0, f};
               pf_tail  = {1'b0, f};
               pf_total = pf_total + TOTAL_W'(1);
               r.status = ST_OK;
            end
         end
         CMD_ALLOC: begin
            if (pf_head == NULL_LINK || !frame_in_range(pf_head)) begin
               r.status = ST_EMPTY;
            end else begin
               h       = pf_head;
               pf_head = pf_next[h[FRAME_W-1:0]];
               if (pf_head == NULL_LINK)
                  pf_tail = NULL_LINK;
               pf_kind[h[FRAME_W-1:0]]  = KIND_ALLOCATED;
               pf_next[h[FRAME_W-1:0]]  = NULL_LINK;
               pf_count[h[FRAME_W-1:0]] = REF_W'(1);
               pf_total    = pf_total - TOTAL_W'(1);
               r.frame_out = h[FRAME_W-1:0];
               r.status    = ST_OK;
            end
         end
         CMD_RELEASE: begin
            if (frame_in_range({1'b0, f}) && pf_kind[f] == KIND_ALLOCATED) begin
               pf_count[f] = pf_count[f] - REF_W'(1);
               if (pf_count[f] == '0) begin
                  pf_kind[f] = KIND_AVAILABLE;
                  pf_next[f] = pf_head;
                  pf_head    = {1'b0, f};
                  if (pf_tail == NULL_LINK)
                     pf_tail = {1'b0, f};
                  pf_total      = pf_total + TOTAL_W'(1);
                  r.frame_freed = 1'b1;
               end
               r.status = ST_OK;
            end
         end
         default: ;
      endcase
      r.free_count = pf_total;
      return r;
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch at word %0d: %s got %0d want %0d", words_checked, what, got, want);
      errors++;
   endtask

   task automatic check_frame_result(rsp_type got);
      rsp_type want;
      if (frame_results_due.size() == 0) begin
         report_mismatch("response with none due, frame_out", 32'(got.frame_out), 0);
         return;
      end
      want = frame_results_due.pop_front();
      if (got.status != want.status)
         report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.frame_out != want.frame_out)
         report_mismatch("frame_out", 32'(got.frame_out), 32'(want.frame_out));
      if (got.free_count != want.free_count)
         report_mismatch("free_count", 32'(got.free_count), 32'(want.free_count));
      if (got.frame_freed != want.frame_freed)
         report_mismatch("frame_freed", 32'(got.frame_freed), 32'(want.frame_freed));
      if (int'(want.free_count) > peak_free)
         peak_free = int'(want.free_count);
      if (want.frame_freed)
         n_freed++;
      if (want.status == ST_EMPTY)
         n_empty++;
      if (want.status == ST_KIND)
         n_kind++;
   endtask

   task automatic queue_word(logic [1:0] cmd, int frame, bit drain);
      pending_word_type p;
      int               idx;
      p.word.command      = cmd;
      p.word.frame_number = frame[FRAME_W-1:0];
      p.drain_first       = drain;
      frame_cmds_pending.push_back(p);
      total_words++;
      case (cmd)
         CMD_ADD: begin
            n_add++;
            if (g_kind[frame] == KIND_RESERVED) begin
               g_kind[frame] = KIND_AVAILABLE;
               g_list.push_back(frame);
            end
         end
         CMD_ALLOC: begin
            n_alloc++;
            if (g_list.size() != 0) begin
               idx = g_list.pop_front();
               g_kind[idx] = KIND_ALLOCATED;
               g_alloc.push_back(idx);
            end
         end
         CMD_RELEASE: begin
            n_release++;
            if (g_kind[frame] == KIND_ALLOCATED) begin
               g_kind[frame] = KIND_AVAILABLE;
               g_list.push_front(frame);
               for (idx = 0; idx < g_alloc.size(); idx++) begin
                  if (g_alloc[idx] == frame) begin
                     g_alloc.delete(idx);
                     break;
                  end
               end
            end
         end
         default: n_other++;
      endcase
   endtask

   task automatic queue_random_word(bit drain);
      int r;
      int frame;
      r     = $urandom_range(0, 99);
      frame = $urandom_range(0, FRAME_LIMIT - 1);
      if (r < 25) begin
         queue_word(CMD_ADD, frame, drain);
      end else if (r < 60) begin
         queue_word(CMD_ALLOC, frame, drain);
      end else if (r < 93) begin
         // mostly release a frame that is really out; else a stray one
         if (g_alloc.size() != 0 && $urandom_range(0, 9) < 8)
            frame = g_alloc[$urandom_range(0, g_alloc.size() - 1)];
         queue_word(CMD_RELEASE, frame, drain);
      end else begin
         queue_word(CMD_UNUSED, frame, drain);
      end
   endtask

   task automatic build_stimulus();
      int spare[$];
      int i, j, t;
      for (i = 0; i < FRAME_LIMIT; i++)
         g_kind[i] = KIND_RESERVED;

      queue_word(CMD_ALLOC,   1023,  1'b0);  // empty list
      queue_word(CMD_RELEASE, 0,     1'b0);  // reserved frame
      queue_word(CMD_UNUSED,  'h2AA, 1'b0);
      queue_word(CMD_ADD,     0,     1'b0);
      queue_word(CMD_ADD,     1023,  1'b0);
      queue_word(CMD_ADD,     0,     1'b0);  // already available
      queue_word(CMD_RELEASE, 1023,  1'b0);  // available, not allocated
      queue_word(CMD_ALLOC,   'h155, 1'b0);
      queue_word(CMD_RELEASE, 0,     1'b0);  // freed, back on the head
      queue_word(CMD_ALLOC,   0,     1'b0);
      queue_word(CMD_ALLOC,   'h3FF, 1'b0);  // last listed frame
      queue_word(CMD_ALLOC,   0,     1'b0);
      queue_word(CMD_RELEASE, 1023,  1'b0);  // into an empty list
      queue_word(CMD_RELEASE, 1023,  1'b0);
      queue_word(CMD_ADD,     512,   1'b0);  // tail must be 1023
      queue_word(CMD_ALLOC,   0,     1'b0);
      queue_word(CMD_ALLOC,   0,     1'b0);
      queue_word(CMD_RELEASE, 0,     1'b0);
      queue_word(CMD_ADD,     1,     1'b0);
      queue_word(CMD_ALLOC,   0,     1'b0);
      queue_word(CMD_ALLOC,   0,     1'b0);
      queue_word(CMD_UNUSED,  1023,  1'b0);

      for (i = 0; i < 300; i++)
         queue_random_word(1'b0);

      // add every frame still reserved, in shuffled order, then release every allocated frame
      for (i = 0; i < FRAME_LIMIT; i++)
         if (g_kind[i] == KIND_RESERVED)
            spare.push_back(i);
      for (i = spare.size() - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         t        = spare[i];
         spare[i] = spare[j];
         spare[j] = t;
      end
      for (i = 0; i < spare.size(); i++)
         queue_word(CMD_ADD, spare[i], i == 0);
      while (g_alloc.size() != 0)
         queue_word(CMD_RELEASE, g_alloc[$urandom_range(0, g_alloc.size() - 1)], 1'b0);
      queue_word(CMD_ADD, $urandom_range(0, FRAME_LIMIT - 1), 1'b0);

      for (i = 0; i < 150; i++)
         queue_random_word(i == 0);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            frame_results_due.push_back(predict_frame_op(req_data));
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            if (frame_cmds_pending.size() != 0
                && !(frame_cmds_pending[0].drain_first && frame_results_due.size() != 0)
                && ((words_sent >= QUIET_LO && words_sent < QUIET_HI)
                    || $urandom_range(0, 99) >= 17)) begin
               req_valid <= 1'b1;
               req_data  <= frame_cmds_pending[0].word;
               frame_cmds_pending.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_frame_result(rsp_data);
            words_checked++;
         end
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (words_checked == HOLD_AT && !hold_done) begin
            // hold off so the block backs up and stalls its input
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (words_checked >= QUIET_LO && words_checked < QUIET_HI)
                         || $urandom_range(0, 99) >= 17;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", stalled_cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < FRAME_LIMIT; i++) begin
         pf_kind[i]  = KIND_RESERVED;
         pf_next[i]  = '0;
         pf_count[i] = '0;
      end
      pf_head  = NULL_LINK;
      pf_tail  = NULL_LINK;
      pf_total = '0;
      build_stimulus();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (words_sent != total_words || frame_results_due.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d words: %0d add, %0d allocate, %0d release, %0d unused command",
               total_words, n_add, n_alloc, n_release, n_other);
      $display("%0d frames freed, %0d empty-list and %0d wrong-kind statuses, peak free %0d",
               n_freed, n_empty, n_kind, peak_free);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", errors);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: sim.f
design/pffl_pkg.sv
design/pffl_ram.sv
design/pffl_update.sv
design/page_frame_free_list.sv
design/pffl_checker.sv
tb/page_frame_free_list_tb.sv
